// ----- hw/rtl/lcdseq_pkg.sv -----
`timescale 1ns / 1ps

package lcdseq_pkg;

  // Command codes
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_PRINT = 3'd1;
  localparam logic [2:0] OP_MOVE  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_RAW   = 3'd4;

  // Fixed timings in microseconds
  localparam logic [13:0] WAIT_PRINT = 14'd40;
  localparam logic [13:0] WAIT_MOVE  = 14'd50;
  localparam logic [13:0] WAIT_CLEAR = 14'd2000;

  // Fixed bytes
  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;
  localparam logic [7:0] CLEAR_BYTE = 8'h01;

  // Six phases per byte: three per nibble
  localparam logic [2:0] BYTE_PHASES = 3'd6;

  // Power-on sequence is split into segments
  localparam int           InitSegs     = 9;
  localparam logic [3:0]   INIT_SEG_END = 4'(InitSegs - 1);

  // Command request
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  byte_value;
    logic        register_select;
    logic [13:0] delay_us;
    logic        row;
    logic [5:0]  column;
  } cmd_req_t;

  // Pin phase request
  typedef struct packed {
    logic [3:0]  data_nibble;
    logic        rs_level;
    logic        enable_level;
    logic [13:0] wait_us;
    logic        last_phase;
  } phase_req_t;

  // One segment of the power-on sequence
  typedef struct packed {
    logic [7:0]  seg_byte;
    logic [13:0] seg_wait;
    logic [2:0]  seg_len;
  } init_seg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_known;
    logic done;
  } dp_status_t;

  // Power-on segments: settle, two single strobes of 0x3, then six bytes
  function automatic init_seg_t init_seg(input logic [3:0] idx);
    init_seg_t s;
    case (idx)
      4'd0:    s = '{8'h00, 14'd15000, 3'd1};
      4'd1:    s = '{8'h30, 14'd4100,  3'd3};
      4'd2:    s = '{8'h30, 14'd100,   3'd3};
      4'd3:    s = '{8'h32, 14'd100,   BYTE_PHASES};
      4'd4:    s = '{8'h28, 14'd40,    BYTE_PHASES};
      4'd5:    s = '{8'h08, 14'd50,    BYTE_PHASES};
      4'd6:    s = '{8'h01, 14'd1640,  BYTE_PHASES};
      4'd7:    s = '{8'h06, 14'd50,    BYTE_PHASES};
      4'd8:    s = '{8'h0C, 14'd50,    BYTE_PHASES};
      default: s = '{8'h00, 14'd0,     3'd1};
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps

// Character LCD write sequencer for a 4-bit data bus.
// Command channel (cmd_valid / cmd_stall / cmd): one request per LCD command:
// initialise, print character, move cursor, clear or raw write. Unknown
// opcodes are accepted and produce nothing.
// Phase channel (phase_valid / phase_stall / phase): one request per pin
// phase: data nibble, RS, E, hold time in microseconds and a last-phase flag.
// Each byte goes out high nibble first, three phases per nibble (set, E high,
// E low). Initialise produces 43 phases, every other command 6.
// After a command is taken, the state register enters run and the first phase is
// then registered into the output register; following phases come one per cycle
// while the receiver does not stall.
// A new command is taken once the final phase sits in the output register,
// even if that phase has not yet been taken.
// When the receiver stalls, the output register holds its phase and the
// sequencer waits; nothing is dropped.
// Reset (rst, synchronous) returns to idle and empties the output register.

module char_lcd_nibble_write_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  lcdseq_pkg::cmd_req_t   cmd,
  output logic                   phase_valid,
  input  logic                   phase_stall,
  output lcdseq_pkg::phase_req_t phase
);
  import lcdseq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lcdseq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .phase_valid (phase_valid),
    .phase_stall (phase_stall),
    .dp_cmd      (dp_cmd),
    .dp_status   (dp_status)
  );

  lcdseq_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .phase     (phase)
  );

endmodule

// ----- hw/rtl/lcdseq_ctrl.sv -----
`timescale 1ns / 1ps

module lcdseq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  output logic                   phase_valid,
  input  logic                   phase_stall,
  output lcdseq_pkg::dp_cmd_t    dp_cmd,
  input  lcdseq_pkg::dp_status_t dp_status
);
  import lcdseq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic accept;
  logic slot_free;

  // Take a request only between commands
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && (state == ST_IDLE);

  // Output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid || !phase_stall;

  assign dp_cmd.load = accept && dp_status.op_known;
  assign dp_cmd.emit = (state == ST_RUN) && slot_free;

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (dp_cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (dp_cmd.emit && dp_status.done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the output valid until taken
  always_comb begin
    if (dp_cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!phase_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign phase_valid = out_valid;

endmodule

// ----- hw/rtl/lcdseq_dp.sv -----
`timescale 1ns / 1ps

module lcdseq_dp (
  input  logic                   clk,
  input  lcdseq_pkg::cmd_req_t   cmd,
  input  lcdseq_pkg::dp_cmd_t    dp_cmd,
  output lcdseq_pkg::dp_status_t dp_status,
  output lcdseq_pkg::phase_req_t phase
);
  import lcdseq_pkg::*;

  logic        is_init;
  logic [7:0]  cmd_byte;
  logic        cmd_rs;
  logic [13:0] cmd_wait;
  logic [3:0]  seg;
  logic [2:0]  step;
  phase_req_t  out_reg;

  logic [7:0]  load_byte;
  logic        load_rs;
  logic [13:0] load_wait;
  logic        op_known;

  init_seg_t   iseg;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic [13:0] cur_wait;
  logic [2:0]  cur_len;
  logic        step_last;
  logic        seg_last;
  phase_req_t  cur_phase;

  // Decode the incoming command into one byte to send
  always_comb begin
    load_byte = cmd.byte_value;
    load_rs   = 1'b0;
    load_wait = cmd.delay_us;
    op_known  = 1'b1;
    case (cmd.opcode)
      OP_INIT: begin
        load_byte = 8'h00;
        load_wait = 14'd0;
      end
      OP_PRINT: begin
        load_rs   = 1'b1;
        load_wait = WAIT_PRINT;
      end
      OP_MOVE: begin
        load_byte = (cmd.row ? LINE1_BASE : LINE0_BASE) + {2'b00, cmd.column};
        load_wait = WAIT_MOVE;
      end
      OP_CLEAR: begin
        load_byte = CLEAR_BYTE;
        load_wait = WAIT_CLEAR;
      end
      OP_RAW: begin
        load_rs = cmd.register_select;
      end
      default: op_known = 1'b0;
    endcase
  end

  // Select the current segment: power-on table or the single loaded byte
  assign iseg = init_seg(seg);

  always_comb begin
    if (is_init) begin
      cur_byte = iseg.seg_byte;
      cur_rs   = 1'b0;
      cur_wait = iseg.seg_wait;
      cur_len  = iseg.seg_len;
    end else begin
      cur_byte = cmd_byte;
      cur_rs   = cmd_rs;
      cur_wait = cmd_wait;
      cur_len  = BYTE_PHASES;
    end
  end

  assign step_last = (step == cur_len - 3'd1);
  assign seg_last  = !is_init || (seg == INIT_SEG_END);

  // Build the pin phase: high nibble on the first three steps, E high mid-nibble
  always_comb begin
    cur_phase.data_nibble  = (step < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
    cur_phase.rs_level     = cur_rs;
    cur_phase.enable_level = (step == 3'd1) || (step == 3'd4);
    cur_phase.wait_us      = cur_wait;
    cur_phase.last_phase   = step_last && seg_last;
  end

  // Load the command, then step through phases and segments
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      is_init  <= (cmd.opcode == OP_INIT);
      cmd_byte <= load_byte;
      cmd_rs   <= load_rs;
      cmd_wait <= load_wait;
      seg      <= 4'd0;
      step     <= 3'd0;
    end else if (dp_cmd.emit) begin
      if (step_last) begin
        step <= 3'd0;
        seg  <= seg + 4'd1;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // Hold the output request until replaced
  always_ff @(posedge clk) begin
    if (dp_cmd.emit) out_reg <= cur_phase;
  end

  assign phase              = out_reg;
  assign dp_status.op_known = op_known;
  assign dp_status.done     = step_last && seg_last;

endmodule
